>>> design/sample_loop_playback_addressing_unit_assert.svh
// Assertion macros for the checker file of this block.
`ifndef SAMPLE_LOOP_PLAYBACK_ADDRESSING_UNIT_ASSERT_SVH
`define SAMPLE_LOOP_PLAYBACK_ADDRESSING_UNIT_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define SLPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked at every rising edge outside reset.
`define SLPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/slpa_pkg.sv
`timescale 1ns / 1ps

package slpa_pkg;

	// Loop table size and the width of an entry number
	localparam int LOOP_ENTRIES = 8;
	localparam int SEL_W = (LOOP_ENTRIES > 1) ? $clog2(LOOP_ENTRIES) : 1;

	// Register limits
	localparam logic [20:0] CHUNK_MAX = 21'd1048576;
	localparam logic [5:0] FRAME_MAX = 6'd32;

	// Request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_FETCH = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_DATA_START = 2'd0;
	localparam logic [1:0] CFG_DATA_STOP = 2'd1;
	localparam logic [1:0] CFG_CHUNK_BYTES = 2'd2;
	localparam logic [1:0] CFG_FRAME_BYTES = 2'd3;

	typedef logic [SEL_W-1:0] sel_t;

	// Search token passed down the cell chain
	typedef struct packed {
		logic vld;
		logic found;
		sel_t sel;
		logic [31:0] lstart;
		logic [31:0] lend;
		logic left_one;
	} pkt_t;

	// Commands broadcast to every cell
	typedef struct packed {
		logic wr_en;
		logic [2:0] wr_idx;
		logic [31:0] wr_start;
		logic [31:0] wr_end;
		logic [31:0] wr_repeat;
		logic wr_enable;
		logic rearm;
		logic hit_en;
		sel_t hit_sel;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_RESP
	} state_t;

	function automatic logic [20:0] clamp_chunk(input logic [20:0] v);
		logic [20:0] r;
		r = v;
		if (v == 21'd0) r = 21'd1;
		else if (v > CHUNK_MAX) r = CHUNK_MAX;
		return r;
	endfunction

	function automatic logic [5:0] clamp_frame(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		if (v == 6'd0) r = 6'd1;
		else if (v > FRAME_MAX) r = FRAME_MAX;
		return r;
	endfunction

endpackage

>>> design/slpa_cell.sv
`timescale 1ns / 1ps

// One loop table entry plus one stage of the search chain.
module slpa_cell import slpa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input sel_t cell_id,
	input logic [31:0] data_start,
	input logic [5:0] frame_bytes,
	input logic [31:0] pos,
	input cell_cmd_t cmd,
	input pkt_t pkt_in,
	output pkt_t pkt_out
);

	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [31:0] init_q;
	logic [31:0] left_q;
	logic active_q;
	logic valid_q;
	logic [31:0] ls;
	logic [31:0] le;
	pkt_t pkt_d;
	pkt_t pkt_q;
	logic wr_me;
	logic hit_me;
	logic match;

	assign wr_me = cmd.wr_en && (int'(cmd.wr_idx) == int'(cell_id));
	assign hit_me = cmd.hit_en && (cmd.hit_sel == cell_id);
	assign match = valid_q && active_q && (pos >= ls) && (pos < le);

	// Byte bounds of the region
	assign ls = data_start + start_q * {26'd0, frame_bytes};
	assign le = data_start + (end_q + 32'd1) * {26'd0, frame_bytes};

	// Entry payload and live count
	always_ff @(posedge clk) begin
		if (cmd.rearm) begin
			if (valid_q) left_q <= init_q;
		end else if (hit_me) begin
			if (left_q != 32'd1 && left_q != 32'd0) left_q <= left_q - 32'd1;
		end else if (wr_me) begin
			start_q <= cmd.wr_start;
			end_q <= cmd.wr_end;
			init_q <= cmd.wr_repeat;
			left_q <= cmd.wr_repeat;
		end
	end

	// Entry flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_q <= 1'b0;
		end else if (cmd.rearm) begin
			active_q <= valid_q;
		end else if (hit_me) begin
			if (left_q == 32'd1) active_q <= 1'b0;
		end else if (wr_me) begin
			active_q <= 1'b0;
			valid_q <= cmd.wr_enable;
		end
	end

	// Search stage: first matching entry claims the token
	always_comb begin
		pkt_d = pkt_in;
		if (pkt_in.vld && !pkt_in.found && match) begin
			pkt_d.found = 1'b1;
			pkt_d.sel = cell_id;
			pkt_d.lstart = ls;
			pkt_d.lend = le;
			pkt_d.left_one = (left_q == 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pkt_q <= '0;
		else pkt_q <= pkt_d;
	end

	assign pkt_out = pkt_q;

endmodule

>>> design/sample_loop_playback_addressing_unit.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    req_type, loop_index, loop_*, play_repeat
// out      out_valid / out_ready  fetch_addr, fetch_len, done_res, looped, restarted, finished
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A live fetch sends a search token into the first cell at the accepting edge; the
// token walks the chain one cell per cycle, then the length stage is registered, the
// state is updated and the result is loaded into the output register. Other requests,
// and a fetch after playback finished, go straight to loading the output register.
// One request is in flight at a time; the output register holds a result while
// out_ready is low, and in_ready returns once that result has been loaded.
// Reset clears the flags of the loop table, the position and the pass count.
module sample_loop_playback_addressing_unit import slpa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] req_type,
	input logic [2:0] loop_index,
	input logic [31:0] loop_start_frame,
	input logic [31:0] loop_end_frame,
	input logic [31:0] loop_repeat,
	input logic loop_enable,
	input logic signed [31:0] play_repeat,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] fetch_addr,
	output logic [20:0] fetch_len,
	output logic done_res,
	output logic looped,
	output logic restarted,
	output logic finished,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);

	state_t state_q, state_d;

	logic [31:0] data_start_q;
	logic [31:0] data_stop_q;
	logic [20:0] chunk_bytes_q;
	logic [5:0] frame_bytes_q;
	logic [20:0] chunk_eff;
	logic [5:0] frame_eff;

	logic [31:0] position_q;
	logic [31:0] passes_q;

	// Length stage results
	logic [20:0] amount_q;
	logic at_end_q;
	logic reach_q;
	logic found_q;
	sel_t sel_q;
	logic [31:0] lstart_q;
	logic left_one_q;

	// Result held until the output register is free
	logic [31:0] res_addr_q;
	logic [20:0] res_len_q;
	logic res_done_q;
	logic res_looped_q;
	logic res_restarted_q;
	logic res_finished_q;

	logic out_valid_q;
	logic [31:0] out_addr_q;
	logic [20:0] out_len_q;
	logic out_done_q;
	logic out_looped_q;
	logic out_restarted_q;
	logic out_finished_q;

	logic accept;
	logic scan_done;
	logic upd_en;
	logic resp_load;
	logic is_fetch;
	logic fetch_live;

	pkt_t chain [LOOP_ENTRIES+1];
	cell_cmd_t cmd;

	logic [31:0] stop;
	logic [32:0] diff;
	logic past;
	logic [31:0] newpos;
	logic take_loop;
	logic data_end;

	assign cfg_ready = 1'b1;
	assign chunk_eff = clamp_chunk(chunk_bytes_q);
	assign frame_eff = clamp_frame(frame_bytes_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_start_q <= 32'd0;
			data_stop_q <= 32'd0;
			chunk_bytes_q <= 21'd16384;
			frame_bytes_q <= 6'd4;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DATA_START: data_start_q <= cfg_data;
				CFG_DATA_STOP: data_stop_q <= cfg_data;
				CFG_CHUNK_BYTES: chunk_bytes_q <= cfg_data[20:0];
				CFG_FRAME_BYTES: frame_bytes_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign is_fetch = (req_type == REQ_FETCH);
	assign fetch_live = is_fetch && (passes_q != 32'd0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = fetch_live ? ST_SCAN : ST_RESP;
			end
			ST_SCAN: begin
				if (chain[LOOP_ENTRIES].vld) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_RESP;
			ST_RESP: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		scan_done = 1'b0;
		upd_en = 1'b0;
		resp_load = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: scan_done = chain[LOOP_ENTRIES].vld;
			ST_UPDATE: upd_en = 1'b1;
			ST_RESP: resp_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Search token enters the first cell on a live fetch
	always_comb begin
		chain[0] = '0;
		chain[0].vld = accept && fetch_live;
	end

	// Update stage decisions
	assign newpos = position_q + {11'd0, amount_q};
	assign take_loop = found_q && reach_q && !left_one_q;
	assign data_end = !take_loop && (at_end_q || newpos >= data_stop_q);

	// Broadcast commands to the cells
	always_comb begin
		cmd.wr_en = accept && (req_type == REQ_WRITE);
		cmd.wr_idx = loop_index;
		cmd.wr_start = loop_start_frame;
		cmd.wr_end = loop_end_frame;
		cmd.wr_repeat = loop_repeat;
		cmd.wr_enable = loop_enable;
		cmd.rearm = (accept && (req_type == REQ_START)) || (upd_en && data_end
			&& passes_q != 32'd1);
		cmd.hit_en = upd_en && found_q && reach_q;
		cmd.hit_sel = sel_q;
	end

	for (genvar i = 0; i < LOOP_ENTRIES; i++) begin : g_cell
		slpa_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cell_id(SEL_W'(i)),
			.data_start(data_start_q),
			.frame_bytes(frame_eff),
			.pos(position_q),
			.cmd(cmd),
			.pkt_in(chain[i]),
			.pkt_out(chain[i+1])
		);
	end

	// Length stage: clip to region end and chunk size
	assign stop = chain[LOOP_ENTRIES].found ? chain[LOOP_ENTRIES].lend : data_stop_q;
	assign diff = {1'b0, stop} - {1'b0, position_q};
	assign past = diff[32];

	always_ff @(posedge clk) begin
		if (scan_done) begin
			if (past) amount_q <= 21'd0;
			else if (diff[31:0] > {11'd0, chunk_eff}) amount_q <= chunk_eff;
			else amount_q <= diff[20:0];
			at_end_q <= past || (diff[31:0] == 32'd0);
			reach_q <= past || (diff[31:0] <= {11'd0, chunk_eff});
			found_q <= chain[LOOP_ENTRIES].found;
			sel_q <= chain[LOOP_ENTRIES].sel;
			lstart_q <= chain[LOOP_ENTRIES].lstart;
			left_one_q <= chain[LOOP_ENTRIES].left_one;
		end
	end

	// Position and pass count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= 32'd0;
			passes_q <= 32'd0;
		end else if (accept && req_type == REQ_START) begin
			position_q <= data_start_q;
			passes_q <= unsigned'(play_repeat);
		end else if (upd_en) begin
			if (data_end) begin
				if (passes_q == 32'd1) begin
					passes_q <= 32'd0;
					position_q <= newpos;
				end else begin
					passes_q <= passes_q[31] ? 32'hFFFF_FFFF : passes_q - 32'd1;
					position_q <= data_start_q;
				end
			end else begin
				position_q <= take_loop ? lstart_q : newpos;
			end
		end
	end

	// Result of the transaction in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			res_addr_q <= (is_fetch && !fetch_live) ? position_q : 32'd0;
			res_len_q <= 21'd0;
			res_done_q <= is_fetch && !fetch_live;
			res_looped_q <= 1'b0;
			res_restarted_q <= 1'b0;
			res_finished_q <= 1'b0;
		end else if (upd_en) begin
			res_addr_q <= position_q;
			res_len_q <= amount_q;
			res_done_q <= 1'b0;
			res_looped_q <= take_loop;
			res_restarted_q <= data_end && (passes_q != 32'd1);
			res_finished_q <= data_end && (passes_q == 32'd1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (resp_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			out_addr_q <= res_addr_q;
			out_len_q <= res_len_q;
			out_done_q <= res_done_q;
			out_looped_q <= res_looped_q;
			out_restarted_q <= res_restarted_q;
			out_finished_q <= res_finished_q;
		end
	end

	assign out_valid = out_valid_q;
	assign fetch_addr = out_addr_q;
	assign fetch_len = out_len_q;
	assign done_res = out_done_q;
	assign looped = out_looped_q;
	assign restarted = out_restarted_q;
	assign finished = out_finished_q;

endmodule

>>> design/slpa_checker.sv
`timescale 1ns / 1ps

`include "sample_loop_playback_addressing_unit_assert.svh"

// Port-level checks of the playback addressing unit.
module slpa_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] fetch_addr,
	input logic [20:0] fetch_len,
	input logic done_res,
	input logic looped,
	input logic restarted,
	input logic finished
);

	// Stalled result holds
	`SLPA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(fetch_addr) && $stable(fetch_len), "result changed while stalled")

	// One transaction at a time: ready drops after an accepted request
	`SLPA_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready,
		"request accepted while another is in flight")

	// A finished playback fetches nothing and reports no event
	`SLPA_ASSERT_IMP(a_done_empty, clk, arst_n, out_valid && done_res,
		fetch_len == 21'd0 && !looped && !restarted && !finished,
		"done result carries a fetch or event")

	// Loop jump, restart and finish exclude each other
	`SLPA_ASSERT_IMP(a_event_excl, clk, arst_n, out_valid,
		$countones({looped, restarted, finished}) <= 1, "more than one position event")

endmodule

bind sample_loop_playback_addressing_unit slpa_checker u_slpa_checker (.*);

>>> sim/slpa_fetch_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels of the playback address unit,
// keeps its own copy of the playback state and checks every result in order.
module slpa_fetch_checker import slpa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [1:0] req_type,
	input logic [2:0] loop_index,
	input logic [31:0] loop_start_frame,
	input logic [31:0] loop_end_frame,
	input logic [31:0] loop_repeat,
	input logic loop_enable,
	input logic signed [31:0] play_repeat,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] fetch_addr,
	input logic [20:0] fetch_len,
	input logic done_res,
	input logic looped,
	input logic restarted,
	input logic finished,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic [31:0] addr;
		logic [20:0] len;
		logic done;
		logic looped;
		logic restarted;
		logic finished;
	} fetch_res_t;

	// Register copies
	logic [31:0] base_addr;
	logic [31:0] stop_addr;
	logic [20:0] chunk_reg;
	logic [5:0] frame_reg;

	// Playback state and loop table
	logic [31:0] play_pos;
	logic [31:0] passes;
	logic [31:0] ent_first [LOOP_ENTRIES];
	logic [31:0] ent_last [LOOP_ENTRIES];
	logic [31:0] ent_count [LOOP_ENTRIES];
	logic [31:0] ent_left [LOOP_ENTRIES];
	logic ent_active [LOOP_ENTRIES];
	logic ent_valid [LOOP_ENTRIES];

	fetch_res_t expected_fetches [$];

	// Reload live counts of valid entries and go back to the data start
	function automatic void rearm_table();
		int i;
		for (i = 0; i < LOOP_ENTRIES; i++) begin
			ent_active[i] = ent_valid[i];
			if (ent_valid[i])
				ent_left[i] = ent_count[i];
		end
		play_pos = base_addr;
	endfunction

	// Apply one request to the state and return the result it produces
	function automatic fetch_res_t next_fetch(input logic [1:0] kind, input logic [2:0] idx,
		input logic [31:0] first, input logic [31:0] last, input logic [31:0] reps,
		input logic en, input logic [31:0] prep);
		fetch_res_t r;
		logic [31:0] chunk, fb, pos, stop, amount, ls, le, lstart;
		logic at_end;
		int hit, i;
		r = '0;
		hit = -1;
		lstart = '0;
		case (kind)
			REQ_WRITE: begin
				ent_first[idx] = first;
				ent_last[idx] = last;
				ent_count[idx] = reps;
				ent_left[idx] = reps;
				ent_valid[idx] = en;
				ent_active[idx] = 1'b0;
			end
			REQ_START: begin
				passes = prep;
				rearm_table();
			end
			REQ_FETCH: begin
				if (passes == 32'd0) begin
					r.addr = play_pos;
					r.done = 1'b1;
				end else begin
					// effective register values
					chunk = {11'd0, chunk_reg};
					if (chunk == 32'd0) chunk = 32'd1;
					if (chunk > 32'd1048576) chunk = 32'd1048576;
					fb = {26'd0, frame_reg};
					if (fb == 32'd0) fb = 32'd1;
					if (fb > 32'd32) fb = 32'd32;

					// first active loop holding the position
					pos = play_pos;
					stop = stop_addr;
					for (i = 0; i < LOOP_ENTRIES; i++) begin
						if (hit < 0 && ent_valid[i] && ent_active[i]) begin
							ls = base_addr + ent_first[i] * fb;
							le = base_addr + (ent_last[i] + 32'd1) * fb;
							if (pos >= ls && pos < le) begin
								stop = le;
								lstart = ls;
								hit = i;
							end
						end
					end

					amount = (pos >= stop) ? 32'd0 : stop - pos;
					if (amount > chunk) amount = chunk;
					at_end = (amount == 32'd0);
					play_pos = pos + amount;

					// loop end: count down, retire or jump back
					if (hit >= 0 && play_pos >= stop) begin
						if (ent_left[hit] == 32'd1) begin
							ent_active[hit] = 1'b0;
						end else begin
							if (ent_left[hit] != 32'd0)
								ent_left[hit] = ent_left[hit] - 32'd1;
							play_pos = lstart;
							r.looped = 1'b1;
						end
					end

					// data end: another pass or done
					if (!r.looped && (at_end || play_pos >= stop_addr)) begin
						if (passes == 32'd1) begin
							passes = 32'd0;
							r.finished = 1'b1;
						end else begin
							if (!passes[31]) passes = passes - 32'd1;
							else passes = '1;
							rearm_table();
							r.restarted = 1'b1;
						end
					end

					r.addr = pos;
					r.len = amount[20:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Track transactions on all three channels
	always @(posedge clk or negedge arst_n) begin
		fetch_res_t exp_r;
		int i;
		if (!arst_n) begin
			base_addr = '0;
			stop_addr = '0;
			chunk_reg = 21'd16384;
			frame_reg = 6'd4;
			play_pos = '0;
			passes = '0;
			for (i = 0; i < LOOP_ENTRIES; i++) begin
				ent_first[i] = '0;
				ent_last[i] = '0;
				ent_count[i] = '0;
				ent_left[i] = '0;
				ent_active[i] = 1'b0;
				ent_valid[i] = 1'b0;
			end
			expected_fetches.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DATA_START: base_addr = cfg_data;
					CFG_DATA_STOP: stop_addr = cfg_data;
					CFG_CHUNK_BYTES: chunk_reg = cfg_data[20:0];
					CFG_FRAME_BYTES: frame_reg = cfg_data[5:0];
					default: ;
				endcase
			end

			if (in_valid && in_ready)
				expected_fetches.push_back(next_fetch(req_type, loop_index, loop_start_frame,
					loop_end_frame, loop_repeat, loop_enable, play_repeat));

			if (out_valid && out_ready) begin
				if (expected_fetches.size() == 0) begin
					$error("unexpected result transaction: fetch_addr %h fetch_len %0d",
						fetch_addr, fetch_len);
					errors++;
				end else begin
					exp_r = expected_fetches.pop_front();
					if (fetch_addr !== exp_r.addr) begin
						$error("fetch_addr: expected %h, got %h", exp_r.addr, fetch_addr);
						errors++;
					end
					if (fetch_len !== exp_r.len) begin
						$error("fetch_len: expected %0d, got %0d", exp_r.len, fetch_len);
						errors++;
					end
					if (done_res !== exp_r.done) begin
						$error("done_res: expected %b, got %b", exp_r.done, done_res);
						errors++;
					end
					if (looped !== exp_r.looped) begin
						$error("looped: expected %b, got %b", exp_r.looped, looped);
						errors++;
					end
					if (restarted !== exp_r.restarted) begin
						$error("restarted: expected %b, got %b", exp_r.restarted, restarted);
						errors++;
					end
					if (finished !== exp_r.finished) begin
						$error("finished: expected %b, got %b", exp_r.finished, finished);
						errors++;
					end
				end
			end
			pending = expected_fetches.size();
		end
	end

endmodule

>>> sim/sample_loop_playback_addressing_unit_tb.sv
`timescale 1ns / 1ps

module sample_loop_playback_addressing_unit_tb;
	import slpa_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int ITEM_TARGET = 900;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] idx;
		logic [31:0] first;
		logic [31:0] last;
		logic [31:0] reps;
		logic en;
		logic [31:0] passes;
	} req_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] req_type;
	logic [2:0] loop_index;
	logic [31:0] loop_start_frame;
	logic [31:0] loop_end_frame;
	logic [31:0] loop_repeat;
	logic loop_enable;
	logic signed [31:0] play_repeat;
	logic out_valid;
	logic out_ready;
	logic [31:0] fetch_addr;
	logic [20:0] fetch_len;
	logic done_res;
	logic looped;
	logic restarted;
	logic finished;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	int errors;
	int pending;
	int items_sent;
	bit calm;

	sample_loop_playback_addressing_unit dut (.*);

	slpa_fetch_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Request payloads
	function automatic req_t kind_req(input logic [1:0] kind);
		req_t r;
		r.kind = kind;
		r.idx = 3'($urandom_range(0, 7));
		r.first = $urandom;
		r.last = $urandom;
		r.reps = $urandom;
		r.en = 1'($urandom_range(0, 1));
		r.passes = $urandom;
		return r;
	endfunction

	function automatic req_t entry_req(input logic [2:0] idx, input logic [31:0] first,
		input logic [31:0] last, input logic [31:0] reps, input logic en);
		req_t r;
		r = kind_req(REQ_WRITE);
		r.idx = idx;
		r.first = first;
		r.last = last;
		r.reps = reps;
		r.en = en;
		return r;
	endfunction

	function automatic req_t start_req(input logic [31:0] p);
		req_t r;
		r = kind_req(REQ_START);
		r.passes = p;
		return r;
	endfunction

	// Mostly short loops inside a small data region; sometimes anything
	function automatic req_t rand_entry();
		req_t r;
		r = kind_req(REQ_WRITE);
		if ($urandom_range(0, 9) != 0) begin
			r.first = $urandom_range(0, 150);
			r.last = ($urandom_range(0, 7) == 0) ? r.first - $urandom_range(1, 3)
				: r.first + $urandom_range(0, 12);
			case ($urandom_range(0, 7))
				0: r.reps = 32'd0;
				1: r.reps = $urandom;
				default: r.reps = $urandom_range(1, 3);
			endcase
			r.en = ($urandom_range(0, 7) != 0);
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_passes();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF;
			1: return $urandom | 32'h8000_0000;
			2: return 32'd0;
			3: return $urandom;
			default: return $urandom_range(1, 3);
		endcase
	endfunction

	// One request transaction, with a random gap in front
	task automatic send_req(input req_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		loop_index <= r.idx;
		loop_start_frame <= r.first;
		loop_end_frame <= r.last;
		loop_repeat <= r.reps;
		loop_enable <= r.en;
		play_repeat <= r.passes;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Stop sending and wait until every result is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_regs(input logic [31:0] base, input logic [31:0] stop,
		input logic [31:0] chunk, input logic [31:0] frame);
		write_reg(CFG_DATA_START, base);
		write_reg(CFG_DATA_STOP, stop);
		write_reg(CFG_CHUNK_BYTES, chunk);
		write_reg(CFG_FRAME_BYTES, frame);
		cfg_valid <= 1'b0;
	endtask

	// Random region and register extremes
	task automatic rand_config();
		logic [31:0] span, base, chunk, frame;
		case ($urandom_range(0, 9))
			0: span = 32'd0;
			1: span = $urandom;
			default: span = $urandom_range(1, 600);
		endcase
		case ($urandom_range(0, 9))
			0, 1: base = 32'hFFFF_FFFF - $urandom_range(0, 300);
			2: base = $urandom;
			default: base = $urandom_range(0, 4096);
		endcase
		case ($urandom_range(0, 9))
			0: chunk = 32'd0;
			1: chunk = 32'd1;
			2: chunk = 32'd1048576;
			3: chunk = $urandom_range(1048577, 2097151) | ($urandom & 32'hFFE0_0000);
			4: chunk = $urandom_range(1, 1048576);
			default: chunk = $urandom_range(1, 64);
		endcase
		case ($urandom_range(0, 7))
			0: frame = 32'd0;
			1: frame = 32'd32;
			2: frame = $urandom_range(33, 63) | ($urandom & 32'hFFFF_FFC0);
			default: frame = $urandom_range(1, 8);
		endcase
		set_regs(base, base + span, chunk, frame);
	endtask

	// Result side: random stalls, some before and some after the result shows
	initial begin
		int w;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			w = calm ? 0 : $urandom_range(0, 8);
			if (w > 0) begin
				out_ready <= 1'b0;
				if ($urandom_range(0, 1) == 1)
					do @(posedge clk); while (!out_valid);
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Watchdog: ends the run after a long stretch with no transaction
	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("sample_loop_playback_addressing_unit_tb: errors");
		$finish;
	end

	// Stimulus
	initial begin
		int m;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_FETCH;
		loop_index = '0;
		loop_start_frame = '0;
		loop_end_frame = '0;
		loop_repeat = '0;
		loop_enable = 1'b0;
		play_repeat = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DATA_START;
		cfg_data = '0;
		calm = 1'b0;
		items_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset: finished playback, unknown request, empty data region
		send_req(kind_req(REQ_FETCH));
		send_req(kind_req(REQ_NONE));
		send_req(start_req(32'd1));
		send_req(kind_req(REQ_FETCH));
		send_req(kind_req(REQ_FETCH));

		// Small region with one loop, a disabled entry and an all-ones entry
		wait_idle();
		set_regs(32'h100, 32'h140, 32'd16, 32'd4);
		send_req(entry_req(3'd0, 32'd2, 32'd5, 32'd2, 1'b1));
		send_req(entry_req(3'd7, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0));
		send_req(entry_req(3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send_req(start_req(32'd2));
		repeat (10) send_req(kind_req(REQ_FETCH));
		send_req(start_req(32'h8000_0000));
		repeat (5) send_req(kind_req(REQ_FETCH));

		// Random phases: new registers, table setup, start, then mostly fetches
		while (items_sent < ITEM_TARGET) begin
			wait_idle();
			calm = ($urandom_range(0, 3) == 0);
			rand_config();
			repeat ($urandom_range(0, 8)) send_req(rand_entry());
			send_req(start_req(rand_passes()));
			m = $urandom_range(10, 40);
			repeat (m) begin
				case ($urandom_range(0, 19))
					0: send_req(rand_entry());
					1: send_req(start_req(rand_passes()));
					2: send_req(kind_req(2'($urandom_range(0, 3))));
					default: send_req(kind_req(REQ_FETCH));
				endcase
			end
		end

		wait_idle();
		repeat (LOOP_ENTRIES + 8) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("sample_loop_playback_addressing_unit_tb: clean");
		else
			$display("sample_loop_playback_addressing_unit_tb: errors");
		$finish;
	end

endmodule
